[hdl/four_lane_multiplicative_hash64_macros.svh]
// Assertion macros for the checker file.
`ifndef FOUR_LANE_MULTIPLICATIVE_HASH64_MACROS_SVH
`define FOUR_LANE_MULTIPLICATIVE_HASH64_MACROS_SVH

`define CHK_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`define CHK_AFTER_RESET(lbl, clk, rst, post) \
   lbl: assert property (@(posedge clk) (rst) |=> (post)) \
      else $error("check failed after reset");

`endif

[hdl/flmh64_pkg.sv]
package flmh64_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int VB_W = 4;
   localparam int NUM_LANES = 4;
   localparam int IDX_W = 2;
   localparam int CSR_ADDR_W = 4;
   localparam logic [VB_W-1:0] FULL_BYTES = 4'd8;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED_ADDR = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MULT_ADDR = 4'h8;

   typedef enum logic [2:0] {
      OP_LANE,
      OP_FOLD,
      OP_GB,
      OP_LAST,
      OP_HEAD,
      OP_TAIL
   } mac_op_type;

   typedef struct packed {
      logic             load;
      logic             push;
      logic             init_val;
      logic             mac_start;
      mac_op_type       op;
      logic [IDX_W-1:0] idx;
      logic             out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] word_idx;
      logic             lane_mode;
      logic [VB_W-1:0]  vbytes;
      logic             final_flag;
      logic             mac_done;
   } dp_stat_type;

endpackage

[hdl/flmh64_req_if.sv]
interface flmh64_req_if import flmh64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic [VB_W-1:0]   valid_bytes;
   logic              final_word;
   modport source (output valid, data_word, valid_bytes, final_word, input ready);
   modport sink (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

[hdl/flmh64_rsp_if.sv]
interface flmh64_rsp_if import flmh64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

[hdl/four_lane_multiplicative_hash64.sv]
// Streaming 64-bit multiplicative hash. Requests arrive on req_if, one little-endian
// 64-bit word each with a valid-byte count and a final flag; one hash per message
// leaves on rsp_if after its final request. Seed and multiplier are written over the
// csr_ port at byte addresses 0 and 8; the user is to write them only while the block
// is idle, and the block itself does not enforce this. Every multiply-add runs on one
// shared 32x32 multiplier. A non-final request returns to idle, or first updates the
// four lane accumulators when it completes a 32-byte group. A final request of an
// empty message loads the seed as its hash without a multiply-add; in general it runs
// up to nine multiply-adds for the lane update, lane folding, serial words and the
// overlapping tail, then loads the hash and raises rsp_if.valid together.
// The output register holds one hash; the block accepts the next request while it
// waits, but a following final request stalls until the receiver takes it.
// Reset clears the CSR and control registers, drops rsp_if.valid and ends any message.
module four_lane_multiplicative_hash64 import flmh64_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   flmh64_req_if.sink            req_if,
   flmh64_rsp_if.source          rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [WORD_W-1:0]     csr_pwdata,
   output logic [WORD_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   logic [WORD_W-1:0] seed_ff;
   logic [WORD_W-1:0] mult_ff;
   logic              csr_wr;
   dp_cmd_type        cmd;
   dp_stat_type       stat;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         mult_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr == CSR_SEED_ADDR) begin
            seed_ff <= csr_pwdata;
         end
         if (csr_paddr == CSR_MULT_ADDR) begin
            mult_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_SEED_ADDR: csr_prdata = seed_ff;
         CSR_MULT_ADDR: csr_prdata = mult_ff;
         default:       csr_prdata = '0;
      endcase
   end

   flmh64_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   flmh64_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .seed        (seed_ff),
      .mult        (mult_ff),
      .data_word   (req_if.data_word),
      .valid_bytes (req_if.valid_bytes),
      .final_word  (req_if.final_word),
      .hash_value  (rsp_if.hash_value)
   );

endmodule

[hdl/flmh64_dp.sv]
module flmh64_dp import flmh64_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [WORD_W-1:0] seed,
   input  logic [WORD_W-1:0] mult,
   input  logic [WORD_W-1:0] data_word,
   input  logic [VB_W-1:0]   valid_bytes,
   input  logic              final_word,
   output logic [WORD_W-1:0] hash_value
);

   logic [WORD_W-1:0] word_ff;
   logic [VB_W-1:0]   vb_ff;
   logic              fin_ff;
   logic [WORD_W-1:0] gb_ff [NUM_LANES];
   logic [WORD_W-1:0] lane_ff [NUM_LANES];
   logic [WORD_W-1:0] tail_ff;
   logic [IDX_W-1:0]  k_ff;
   logic              mode_ff;
   logic [WORD_W-1:0] val_ff;
   logic [WORD_W-1:0] hash_ff;
   logic [WORD_W-1:0] a_ff;
   logic [WORD_W-1:0] b_ff;
   mac_op_type        op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [1:0]        ph_ff;
   logic              busy_ff;
   logic [WORD_W-1:0] plo_ff;
   logic [HALF_W-1:0] cross_ff;

   logic [WORD_W-1:0] wm;
   logic [HALF_W-1:0] head_piece;
   logic [HALF_W-1:0] tail_piece;
   logic [WORD_W-1:0] tail_shifted;
   logic [2:0]        tail_sh;
   logic [5:0]        byte_sh;
   logic [6:0]        left_sh;
   logic [WORD_W-1:0] last_word;
   logic [WORD_W-1:0] addend;
   logic [WORD_W-1:0] acc_src;
   logic [HALF_W-1:0] mul_x;
   logic [HALF_W-1:0] mul_y;
   logic [WORD_W-1:0] prod;
   logic [WORD_W-1:0] mac_res;
   logic              mac_done;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         wm[8*b +: 8] = (VB_W'(b) < vb_ff) ? word_ff[8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      if (vb_ff > 4'd4) begin
         head_piece = wm[31:0];
         tail_sh = 3'(vb_ff - 4'd4);
      end else if (vb_ff >= 4'd2) begin
         head_piece = {16'h0000, wm[15:0]};
         tail_sh = 3'(vb_ff - 4'd2);
      end else begin
         head_piece = {24'h000000, wm[7:0]};
         tail_sh = 3'd0;
      end
      tail_shifted = wm >> {tail_sh, 3'b000};
      tail_piece = (vb_ff > 4'd4) ? tail_shifted[31:0] : {16'h0000, tail_shifted[15:0]};
      byte_sh = {vb_ff[2:0], 3'b000};
      left_sh = 7'd64 - {1'b0, byte_sh};
      last_word = (vb_ff == '0) ? tail_ff : ((tail_ff >> byte_sh) | (wm << left_sh));
   end

   always_comb begin
      case (cmd.op)
         OP_LANE: addend = gb_ff[cmd.idx];
         OP_FOLD: addend = lane_ff[cmd.idx];
         OP_GB:   addend = gb_ff[cmd.idx];
         OP_LAST: addend = last_word;
         OP_HEAD: addend = {32'h0, head_piece};
         OP_TAIL: addend = {32'h0, tail_piece};
         default: addend = '0;
      endcase
      acc_src = (cmd.op == OP_LANE) ? lane_ff[cmd.idx] : val_ff;
   end

   always_comb begin
      case (ph_ff)
         2'd0:    begin mul_x = a_ff[31:0];  mul_y = mult[31:0];  end
         2'd1:    begin mul_x = a_ff[31:0];  mul_y = mult[63:32]; end
         default: begin mul_x = a_ff[63:32]; mul_y = mult[31:0];  end
      endcase
      prod = {32'h0, mul_x} * {32'h0, mul_y};
      mac_res = plo_ff + {cross_ff, 32'h0} + b_ff;
      mac_done = busy_ff && (ph_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= data_word;
         vb_ff <= (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
         fin_ff <= final_word;
      end
      if (cmd.push) begin
         gb_ff[k_ff] <= word_ff;
         if (fin_ff) begin
            vb_ff <= '0;
         end
         if ((k_ff == 2'd3) && !mode_ff) begin
            for (int i = 0; i < NUM_LANES; i++) begin
               lane_ff[i] <= seed;
            end
         end
      end
      if (cmd.mac_start) begin
         a_ff <= acc_src;
         b_ff <= addend;
         op_ff <= cmd.op;
         idx_ff <= cmd.idx;
      end
      if (busy_ff) begin
         case (ph_ff)
            2'd0:    plo_ff <= prod;
            2'd1:    cross_ff <= prod[31:0];
            2'd2:    cross_ff <= cross_ff + prod[31:0];
            default: begin
               if (op_ff == OP_LANE) begin
                  lane_ff[idx_ff] <= mac_res;
               end else begin
                  val_ff <= mac_res;
               end
            end
         endcase
      end
      if (cmd.init_val) begin
         val_ff <= seed;
      end
      if (cmd.out_load) begin
         hash_ff <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         mode_ff <= 1'b0;
         tail_ff <= '0;
         busy_ff <= 1'b0;
         ph_ff <= '0;
      end else begin
         if (cmd.push) begin
            tail_ff <= word_ff;
            k_ff <= k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               mode_ff <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            k_ff <= '0;
            mode_ff <= 1'b0;
            tail_ff <= '0;
         end
         if (cmd.mac_start) begin
            busy_ff <= 1'b1;
            ph_ff <= '0;
         end else if (busy_ff) begin
            ph_ff <= ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign stat.word_idx = k_ff;
   assign stat.lane_mode = mode_ff;
   assign stat.vbytes = vb_ff;
   assign stat.final_flag = fin_ff;
   assign stat.mac_done = mac_done;
   assign hash_value = hash_ff;

endmodule

[hdl/flmh64_ctrl.sv]
module flmh64_ctrl import flmh64_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_LANE,
      S_FINAL,
      S_FOLD,
      S_GB,
      S_LAST,
      S_HEAD,
      S_TAIL,
      S_OUT
   } state_type;

   state_type        state_ff;
   logic             pending_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;

   logic [IDX_W-1:0] gb_n;
   logic             is_op;
   logic             out_free;

   always_comb begin
      gb_n = ((stat.vbytes == '0) && (stat.word_idx != '0)) ? (stat.word_idx - 2'd1)
                                                            : stat.word_idx;
      out_free = !rsp_valid_ff || rsp_ready;
      is_op = (state_ff == S_LANE) || (state_ff == S_FOLD) || (state_ff == S_GB) ||
              (state_ff == S_LAST) || (state_ff == S_HEAD) || (state_ff == S_TAIL);
      cmd = '0;
      cmd.idx = idx_ff;
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.push = (state_ff == S_DECIDE) && (!stat.final_flag || (stat.vbytes == FULL_BYTES));
      cmd.init_val = (state_ff == S_FINAL);
      cmd.mac_start = is_op && !pending_ff;
      cmd.out_load = (state_ff == S_OUT) && out_free;
      unique case (state_ff)
         S_LANE:  cmd.op = OP_LANE;
         S_FOLD:  cmd.op = OP_FOLD;
         S_GB:    cmd.op = OP_GB;
         S_LAST:  cmd.op = OP_LAST;
         S_HEAD:  cmd.op = OP_HEAD;
         S_TAIL:  cmd.op = OP_TAIL;
         default: cmd.op = OP_LANE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pending_ff <= 1'b0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.mac_start) begin
            pending_ff <= 1'b1;
         end else if (stat.mac_done) begin
            pending_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               idx_ff <= '0;
               if (cmd.push && (stat.word_idx == 2'd3)) begin
                  state_ff <= S_LANE;
               end else if (stat.final_flag) begin
                  state_ff <= S_FINAL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_LANE: begin
               if (pending_ff && stat.mac_done) begin
                  idx_ff <= idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     state_ff <= stat.final_flag ? S_FINAL : S_IDLE;
                  end
               end
            end
            S_FINAL: begin
               idx_ff <= '0;
               if (!stat.lane_mode && (stat.word_idx == '0)) begin
                  state_ff <= (stat.vbytes == '0) ? S_OUT : S_HEAD;
               end else if (stat.lane_mode) begin
                  state_ff <= S_FOLD;
               end else begin
                  state_ff <= (gb_n == '0) ? S_LAST : S_GB;
               end
            end
            S_FOLD: begin
               if (pending_ff && stat.mac_done) begin
                  idx_ff <= idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     state_ff <= (gb_n == '0) ? S_LAST : S_GB;
                  end
               end
            end
            S_GB: begin
               if (pending_ff && stat.mac_done) begin
                  idx_ff <= idx_ff + 2'd1;
                  if ((idx_ff + 2'd1) == gb_n) begin
                     state_ff <= S_LAST;
                  end
               end
            end
            S_LAST: begin
               if (pending_ff && stat.mac_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_HEAD: begin
               if (pending_ff && stat.mac_done) begin
                  state_ff <= (stat.vbytes == 4'd1) ? S_OUT : S_TAIL;
               end
            end
            S_TAIL: begin
               if (pending_ff && stat.mac_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/flmh64_checker.sv]
`include "four_lane_multiplicative_hash64_macros.svh"

module flmh64_checker import flmh64_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_final,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_hash
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_hash))
   `CHK_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `CHK_NEXT(a_no_rsp_on_word, clock, reset, req_valid && req_ready && !req_final, !$rose(rsp_valid))
   `CHK_AFTER_RESET(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind four_lane_multiplicative_hash64 flmh64_checker u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_final (req_if.final_word),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_hash  (rsp_if.hash_value)
);
